// ===== rtl/btt_pkg.sv =====
// Shared types and constants of the bitset tuple table.
package btt_pkg;

    localparam int FW        = 4;
    localparam int NFIELDS   = 4;
    localparam int S_DATA_W  = 16;
    localparam int POS_OUT_W = 8;
    localparam int CNT_OUT_W = 9;
    localparam int M_DATA_W  = 24;
    localparam int M_USER_W  = 2;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic                         remove;
        logic                         bad;
        logic [NFIELDS-1:0][FW-1:0]   val;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ===== rtl/btt_front.sv =====
// Front end: accepts input transactions, unpacks and range checks the values.
module btt_front import btt_pkg::*; #(
    parameter int ARITY       = 4,
    parameter int DOMAIN_SIZE = 16
) (
    input  logic                i_tvalid,
    output logic                o_tready,
    input  logic [S_DATA_W-1:0] i_tdata,
    input  logic                i_tuser,
    input  t_q_stat             i_q,
    output logic                o_push,
    output t_cmd                o_cmd
);

    always_comb begin
        o_cmd.remove = (i_tuser == OP_REMOVE);
        o_cmd.bad    = 1'b0;
        for (int k = 0; k < NFIELDS; k++) begin
            o_cmd.val[k] = i_tdata[k*FW +: FW];
            if (k < ARITY && int'(i_tdata[k*FW +: FW]) >= DOMAIN_SIZE) begin
                o_cmd.bad = 1'b1;
            end
        end
    end

    assign o_tready = !i_q.full;
    assign o_push   = i_tvalid && o_tready;

endmodule

// ===== rtl/btt_fifo.sv =====
// Two-entry command queue between the front end and the table engine.
module btt_fifo import btt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);

endmodule

// ===== rtl/btt_back.sv =====
// Table engine: bitmap memories, add and first-match remove sequencer, result register.
module btt_back import btt_pkg::*; #(
    parameter int ARITY       = 4,
    parameter int DOMAIN_SIZE = 16,
    parameter int MAX_TUPLES  = 256,
    parameter int WORD_BITS   = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  t_q_stat             i_q,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic [M_USER_W-1:0] o_m_tuser
);

    localparam int NWORDS = (MAX_TUPLES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int VAL_W  = $clog2(DOMAIN_SIZE);
    localparam int ADDR_W = VAL_W + WIDX_W;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int CNT_W  = $clog2(MAX_TUPLES + 1);
    localparam int POS_W  = $clog2(MAX_TUPLES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_EVAL,
        S_FIND,
        S_OUT
    } t_state;

    t_state                r_state;
    t_cmd                  r_cmd;
    logic [WIDX_W-1:0]     r_widx;
    logic [POS_W-1:0]      r_pbase;
    logic [CNT_W-1:0]      r_cnt;
    logic [WIDX_W-1:0]     r_cw;
    logic [BIT_W-1:0]      r_cb;
    logic [WORD_BITS-1:0]  r_and;
    logic [WORD_BITS-1:0]  r_mem [ARITY][DEPTH];
    logic [WORD_BITS-1:0]  r_rd  [ARITY];
    logic [ARITY-1:0]      r_rdv;
    logic [DEPTH-1:0]      r_vld [ARITY];
    logic                  r_pok;
    logic                  r_pfull;
    logic [POS_W-1:0]      r_ppos;
    logic                  r_m_valid;
    logic                  r_m_ok;
    logic                  r_m_full;
    logic [POS_W-1:0]      r_m_pos;
    logic [CNT_W-1:0]      r_m_cnt;

    logic [VAL_W-1:0]      vals   [ARITY];
    logic [ADDR_W-1:0]     addr   [ARITY];
    logic [WORD_BITS-1:0]  rd_eff [ARITY];
    logic [WORD_BITS-1:0]  wdata  [ARITY];
    logic [WORD_BITS-1:0]  and_all;
    logic [BIT_W-1:0]      lb;
    logic                  hit;
    logic                  full;
    logic                  rd_en;
    logic                  mem_we;
    logic                  out_load;
    logic [POS_W+POS_OUT_W-1:0] pext;
    logic [CNT_W+CNT_OUT_W-1:0] cext;

    // variables past the input fields look up value 0
    for (genvar g = 0; g < ARITY; g++) begin : g_val
        if (g < NFIELDS) begin : g_field
            logic [FW+VAL_W-1:0] vext;
            assign vext    = {{VAL_W{1'b0}}, r_cmd.val[g]};
            assign vals[g] = vext[VAL_W-1:0];
        end else begin : g_zero
            assign vals[g] = '0;
        end
        assign addr[g] = {vals[g], r_widx};
    end

    assign full     = (r_cnt == CNT_W'(MAX_TUPLES));
    assign rd_en    = (r_state == S_DISP) && !r_cmd.bad && (r_cmd.remove || !full);
    assign hit      = |r_and;
    assign mem_we   = ((r_state == S_EVAL) && !r_cmd.remove) || ((r_state == S_FIND) && hit);
    assign o_pop    = (r_state == S_IDLE) && !i_q.empty;
    assign out_load = (r_state == S_OUT) && (!r_m_valid || i_m_tready);

    always_comb begin
        and_all = '1;
        for (int i = 0; i < ARITY; i++) begin
            rd_eff[i] = r_rdv[i] ? r_rd[i] : '0;
            and_all   = and_all & rd_eff[i];
        end
    end

    always_comb begin
        lb = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (r_and[k]) begin
                lb = BIT_W'(k);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < ARITY; i++) begin
            if (r_cmd.remove) begin
                wdata[i] = rd_eff[i] & ~(WORD_BITS'(1) << lb);
            end else begin
                wdata[i] = rd_eff[i] | (WORD_BITS'(1) << r_cb);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ARITY; i++) begin
            if (mem_we) begin
                r_mem[i][addr[i]] <= wdata[i];
            end
            if (rd_en) begin
                r_rd[i] <= r_mem[i][addr[i]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_cw      <= '0;
            r_cb      <= '0;
            r_rdv     <= '0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < ARITY; i++) begin
                r_vld[i] <= '0;
            end
        end else begin
            for (int i = 0; i < ARITY; i++) begin
                if (rd_en) begin
                    r_rdv[i] <= r_vld[i][addr[i]];
                end
                if (mem_we) begin
                    r_vld[i][addr[i]] <= 1'b1;
                end
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q.empty) begin
                        r_cmd   <= i_cmd;
                        r_widx  <= i_cmd.remove ? '0 : r_cw;
                        r_pbase <= '0;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    if (r_cmd.bad) begin
                        r_pok   <= 1'b0;
                        r_pfull <= 1'b0;
                        r_ppos  <= '0;
                        r_state <= S_OUT;
                    end else if (!r_cmd.remove && full) begin
                        r_pok   <= 1'b0;
                        r_pfull <= 1'b1;
                        r_ppos  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (!r_cmd.remove) begin
                        r_pok   <= 1'b1;
                        r_pfull <= 1'b0;
                        r_ppos  <= r_cnt[POS_W-1:0];
                        r_cnt   <= r_cnt + CNT_W'(1);
                        if (r_cb == BIT_W'(WORD_BITS - 1)) begin
                            r_cb <= '0;
                            r_cw <= r_cw + WIDX_W'(1);
                        end else begin
                            r_cb <= r_cb + BIT_W'(1);
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_and   <= and_all;
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (hit) begin
                        r_pok   <= 1'b1;
                        r_pfull <= 1'b0;
                        r_ppos  <= r_pbase + POS_W'(lb);
                        if (r_cnt != '0) begin
                            r_cnt <= r_cnt - CNT_W'(1);
                            if (r_cb == '0) begin
                                r_cb <= BIT_W'(WORD_BITS - 1);
                                r_cw <= r_cw - WIDX_W'(1);
                            end else begin
                                r_cb <= r_cb - BIT_W'(1);
                            end
                        end
                        r_state <= S_OUT;
                    end else if (r_widx == WIDX_W'(NWORDS - 1)) begin
                        r_pok   <= 1'b0;
                        r_pfull <= 1'b0;
                        r_ppos  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_widx  <= r_widx + WIDX_W'(1);
                        r_pbase <= r_pbase + POS_W'(WORD_BITS);
                        r_state <= S_DISP;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_m_ok    <= r_pok;
                        r_m_full  <= r_pfull;
                        r_m_pos   <= r_ppos;
                        r_m_cnt   <= r_cnt;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign pext       = {{POS_OUT_W{1'b0}}, r_m_pos};
    assign cext       = {{CNT_OUT_W{1'b0}}, r_m_cnt};
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(M_DATA_W - POS_OUT_W - CNT_OUT_W){1'b0}},
                         cext[CNT_OUT_W-1:0], pext[POS_OUT_W-1:0]};
    assign o_m_tuser  = {r_m_full, r_m_ok};

endmodule

// ===== rtl/bitset_tuple_table.sv =====
// Top level of the bitset tuple table.
//
// Slave stream: one transaction per tuple. tuser selects add (0) or remove (1),
// tdata carries the four 4-bit value indices. Master stream: one result per
// accepted transaction, in order: succeeded and full flags in tuser, position
// and tuple count in tdata.
// A front end checks the values and loads a two-entry command queue; the table
// engine works one command at a time against per-variable bitmap memories of
// MAX_TUPLES/WORD_BITS words per value.
// From the queue, an add passes through dispatch, evaluate and output; a full
// store or an out-of-range value goes from dispatch straight to output; a
// remove repeats dispatch, evaluate and find per bitmap word (one read, one AND,
// one search per word) until it hits or passes the last word, then goes to output.
// The engine takes a new command only after the result of the last one is loaded.
// Reset clears the count and the per-entry valid bits at once, so every bitmap
// reads as zero with no sweep; the block accepts items as soon as reset is
// released. When the receiver stalls, the result holds in the output register,
// the engine waits with the next result, and input transactions are taken
// until the command queue fills.
module bitset_tuple_table import btt_pkg::*; #(
    parameter int ARITY       = 4,
    parameter int DOMAIN_SIZE = 16,
    parameter int MAX_TUPLES  = 256,
    parameter int WORD_BITS   = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // value_0, value_1, value_2, value_3
    input  logic                s_axis_tuser,  // operation
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,  // position, tuple_count, zero pad
    output logic [M_USER_W-1:0] m_axis_tuser   // succeeded, full_res
);

    t_cmd    front_cmd;
    t_cmd    q_cmd;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    btt_front #(
        .ARITY       (ARITY),
        .DOMAIN_SIZE (DOMAIN_SIZE)
    ) u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_q      (q_stat),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    btt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    btt_back #(
        .ARITY       (ARITY),
        .DOMAIN_SIZE (DOMAIN_SIZE),
        .MAX_TUPLES  (MAX_TUPLES),
        .WORD_BITS   (WORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (q_cmd),
        .i_q        (q_stat),
        .o_pop      (pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/btt_checker.sv =====
// Port-level assertions for the bitset tuple table, bound to the top level.
module btt_checker import btt_pkg::*; #(
    parameter int MAX_TUPLES = 256
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic [M_USER_W-1:0] m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("succeeded and full both set");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[POS_OUT_W-1:0] == '0)
        else $error("position not zero on failed item");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[POS_OUT_W +: CNT_OUT_W] == CNT_OUT_W'(MAX_TUPLES))
        else $error("full reported below capacity");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind bitset_tuple_table btt_checker #(.MAX_TUPLES(MAX_TUPLES)) u_btt_checker (.*);

// ===== tb/bitset_tuple_table_tb.sv =====
// Self-checking testbench of the bitset tuple table: directed, fill-to-full and random tests.
module bitset_tuple_table_tb;
    import btt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ARITY       = 4;
    localparam int DOMAIN_SIZE = 16;
    localparam int MAX_TUPLES  = 256;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_TIME  = 20;

    typedef struct packed {
        logic       succeeded;
        logic       full_res;
        logic [7:0] position;
        logic [8:0] tuple_count;
    } t_table_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;   // value_0, value_1, value_2, value_3
    logic                s_axis_tuser = 1'b0; // operation
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;        // position, tuple_count, zero pad
    logic [M_USER_W-1:0] m_axis_tuser;        // succeeded, full_res

    logic [MAX_TUPLES-1:0] value_map [ARITY][DOMAIN_SIZE];
    int unsigned           stored_count;
    t_table_result         pending_results[$];
    logic [15:0]           added_tuples[$];
    int unsigned           mismatch_count = 0;
    int unsigned           idle_cycles = 0;
    int unsigned           sink_hold = 0;
    bit                    source_calm;
    bit                    sink_calm;

    bitset_tuple_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_table_result apply_tuple_op(logic op, logic [15:0] vals);
        t_table_result r;
        logic [3:0]    v [ARITY];
        logic          hit;
        int            p;
        r = '0;
        for (int i = 0; i < ARITY; i++) v[i] = vals[4*i +: 4];
        if (op == OP_ADD) begin
            if (stored_count >= MAX_TUPLES) begin
                r.full_res = 1'b1;
            end else begin
                for (int i = 0; i < ARITY; i++) value_map[i][v[i]][stored_count] = 1'b1;
                r.succeeded = 1'b1;
                r.position  = stored_count[7:0];
                stored_count++;
            end
        end else begin
            hit = 1'b0;
            for (p = 0; p < MAX_TUPLES && !hit; p++) begin
                if (value_map[0][v[0]][p] && value_map[1][v[1]][p] &&
                    value_map[2][v[2]][p] && value_map[3][v[3]][p]) begin
                    for (int i = 0; i < ARITY; i++) value_map[i][v[i]][p] = 1'b0;
                    hit         = 1'b1;
                    r.succeeded = 1'b1;
                    r.position  = p[7:0];
                    if (stored_count > 0) stored_count--;
                end
            end
        end
        r.tuple_count = stored_count[8:0];
        return r;
    endfunction

    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [15:0] random_tuple();
        logic [15:0] t;
        t = 16'($urandom);
        // narrow values make removals hit more often
        if ($urandom_range(0, 1) == 0) t = t & 16'h3333;
        return t;
    endfunction

    // starts and ends at a falling edge
    task automatic send_tuple(logic op, logic [15:0] vals);
        int unsigned gap;
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = vals;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(apply_tuple_op(op, vals));
        if (op == OP_ADD) added_tuples.push_back(vals);
        @(negedge i_clk);
        gap = pick_gap(source_calm);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_random_removal();
        if (added_tuples.size() > 0 && $urandom_range(0, 9) < 7)
            send_tuple(OP_REMOVE, added_tuples[$urandom_range(0, added_tuples.size() - 1)]);
        else
            send_tuple(OP_REMOVE, random_tuple());
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 30) sink_hold <= pick_gap(sink_calm);
        end
    end

    always @(posedge i_clk) begin
        t_table_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result tuser=%b tdata=%h", $time,
                         m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tuser[0] !== exp_r.succeeded) begin
                    $display("%0t: succeeded expected %0d actual %0d", $time,
                             exp_r.succeeded, m_axis_tuser[0]);
                    mismatch_count++;
                end
                if (m_axis_tuser[1] !== exp_r.full_res) begin
                    $display("%0t: full_res expected %0d actual %0d", $time,
                             exp_r.full_res, m_axis_tuser[1]);
                    mismatch_count++;
                end
                if (m_axis_tdata[7:0] !== exp_r.position) begin
                    $display("%0t: position expected %0d actual %0d", $time,
                             exp_r.position, m_axis_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[16:8] !== exp_r.tuple_count) begin
                    $display("%0t: tuple_count expected %0d actual %0d", $time,
                             exp_r.tuple_count, m_axis_tdata[16:8]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic test_directed();
        source_calm = 1'b0;
        sink_calm   = 1'b0;
        send_tuple(OP_REMOVE, 16'h0000);   // removal on an empty store
        send_tuple(OP_ADD,    16'h0000);
        send_tuple(OP_ADD,    16'hFFFF);
        send_tuple(OP_ADD,    16'h8421);
        send_tuple(OP_REMOVE, 16'hFFFF);
        send_tuple(OP_REMOVE, 16'hFFFF);   // miss
        send_tuple(OP_ADD,    16'h7BDE);   // lands on a position still holding bits
        send_tuple(OP_REMOVE, 16'h74D1);   // mix of the two overlapped tuples
        send_tuple(OP_REMOVE, 16'h8421);   // miss, part of it was cleared
        send_tuple(OP_REMOVE, 16'h8B2E);   // the other mix
        send_tuple(OP_REMOVE, 16'h0000);
        send_tuple(OP_REMOVE, 16'h0000);   // miss at zero count
        send_tuple(OP_ADD,    16'h0F0F);
        send_tuple(OP_ADD,    16'hF0F0);
        send_tuple(OP_REMOVE, 16'hF0F0);
        send_tuple(OP_REMOVE, 16'h0F0F);
    endtask

    task automatic test_fill_to_full();
        source_calm = 1'b1;
        sink_calm   = 1'b1;
        while (stored_count < MAX_TUPLES) send_tuple(OP_ADD, random_tuple());
        source_calm = 1'b0;
        sink_calm   = 1'b0;
        repeat (3) send_tuple(OP_ADD, random_tuple());   // refused, store full
        send_tuple(OP_REMOVE, added_tuples[added_tuples.size() - 1]);
        send_tuple(OP_REMOVE, 16'hFEDC);                  // likely a miss over all words
        send_tuple(OP_ADD, 16'hFFFF);
        send_tuple(OP_ADD, 16'h1234);                     // full again
        repeat (4) send_random_removal();
    endtask

    task automatic test_random_traffic();
        int unsigned add_pct;
        for (int i = 0; i < 500; i++) begin
            if (i % 100 == 0) begin
                case ((i / 100) % 3)
                    0: add_pct = 20;
                    1: add_pct = 50;
                    default: add_pct = 80;
                endcase
                source_calm = (i / 100 == 3);
                sink_calm   = (i / 100 == 3);
            end
            if ($urandom_range(0, 99) < add_pct)
                send_tuple(OP_ADD, random_tuple());
            else
                send_random_removal();
        end
    endtask

    initial begin
        for (int i = 0; i < ARITY; i++)
            for (int j = 0; j < DOMAIN_SIZE; j++) value_map[i][j] = '0;
        stored_count   = 0;
        source_calm    = 1'b0;
        sink_calm      = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_fill_to_full();
        test_random_traffic();

        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_TIME) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
